// ===== design/pchm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pchm_pkg
// Shared types and constants of the PDM channel health monitor.
// ----------------------------------------------------------------------------
package pchm_pkg;

  // operation codes
  localparam logic [1:0] OP_OBSERVE     = 2'd0;
  localparam logic [1:0] OP_HEALTH      = 2'd1;
  localparam logic [1:0] OP_POLICY      = 2'd2;
  localparam logic [1:0] OP_FINGERPRINT = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLK_LO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLK_HI = 2'd2;

  localparam logic [31:0] CLK_LO_RESET = 32'd1000000;
  localparam logic [31:0] CLK_HI_RESET = 32'd4800000;

  // health levels
  localparam logic [1:0] LVL_UNKNOWN = 2'd0;
  localparam logic [1:0] LVL_GOOD    = 2'd1;
  localparam logic [1:0] LVL_WARN    = 2'd2;
  localparam logic [1:0] LVL_FAIL    = 2'd3;

  // reason bits
  localparam logic [5:0] RSN_NODATA  = 6'd1;
  localparam logic [5:0] RSN_STUCK   = 6'd2;
  localparam logic [5:0] RSN_DUP     = 6'd4;
  localparam logic [5:0] RSN_SPAN    = 6'd8;
  localparam logic [5:0] RSN_EDGE    = 6'd16;
  localparam logic [5:0] RSN_CLOCK   = 6'd32;

  localparam logic [9:0] SCORE_FULL  = 10'd1000;
  localparam logic [9:0] PEN_STUCK   = 10'd450;
  localparam logic [9:0] PEN_DUP     = 10'd250;
  localparam logic [9:0] PEN_SPAN    = 10'd160;
  localparam logic [9:0] PEN_EDGE    = 10'd300;
  localparam logic [9:0] PEN_CLOCK   = 10'd400;

  localparam logic [31:0] SPAN_LIMIT = 32'd700;
  localparam logic [47:0] AVG_LOW    = 48'd25;
  localparam logic [47:0] AVG_HIGH   = 48'd950;
  localparam logic [31:0] MIN_WINDOWS = 32'd8;
  localparam logic [9:0]  PERMILLE   = 10'd1000;

  localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;
  // ceil(2^34 / 5), exact quotient for any 32-bit dividend
  localparam logic [31:0] RECIP5     = 32'hCCCCCCCD;

  // shared divider widths
  localparam int unsigned DIV_NW = 48;
  localparam int unsigned DIV_DW = 32;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] window_clocks;
    logic [3:0]  window_channels;
    logic [3:0]  duplicate_bits;
    logic [31:0] clock_rate_hz;
    logic [31:0] ones_ch01;
    logic [31:0] ones_ch23;
    logic [31:0] edges_ch01;
    logic [31:0] edges_ch23;
    logic [3:0]  query_channel;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  health_level;
    logic [9:0]  health_score;
    logic [5:0]  reason_bits;
    logic [9:0]  density_floor;
    logic [9:0]  density_ceiling;
    logic [9:0]  edge_floor;
    logic [9:0]  edge_ceiling;
    logic [31:0] clock_floor_hz;
    logic [31:0] clock_ceiling_hz;
    logic [3:0]  policy_channels;
    logic [31:0] fingerprint;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

  // 16-bit count of one channel from its packed pair word
  function automatic logic [15:0] lane16(logic [31:0] w01, logic [31:0] w23,
                                         logic [1:0] c);
    logic [31:0] w;
    w = c[1] ? w23 : w01;
    return c[0] ? w[31:16] : w[15:0];
  endfunction

endpackage

// ===== design/pdm_channel_health_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdm_channel_health_monitor
// Four-channel PDM health statistics with a shared divider and a sequencer.
// ----------------------------------------------------------------------------
// Usage: an input word (opcode plus window data) is taken on the in channel
// when in_valid_i is high and in_stall_o low; exactly one result word leaves
// on the out channel, held in an output register until out_stall_i is low.
// Registers are written over the cfg channel (ready always high); the user
// must write them only while idle: the block does not enforce it. Writing
// channel_enable clears all statistics. One word is worked on at a time and
// in_stall_o stays high meanwhile. Work per word (48-step shared divider):
//   observe: two divisions per present and enabled channel; health: one
//   division; policy: a scan of the channels, two multiply steps and a final
//   step; fingerprint: one byte of the hash a cycle through the FNV multiply.
// A rejected window or a no-data query goes straight to the response step.
// A finished result waits in an internal register while the output register
// is stalled; the next word is taken as soon as the result has moved out.
// Reset clears statistics and loads the register reset values.
// ----------------------------------------------------------------------------
module pdm_channel_health_monitor #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  pchm_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output pchm_pkg::out_t                     out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pchm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]                        cfg_data_i
);
  import pchm_pkg::*;

  localparam int unsigned CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CNTW = $clog2(CHANNELS + 1);
  localparam logic [CNTW-1:0] CH_END  = CNTW'(CHANNELS);
  localparam logic [CNTW-1:0] CH_LAST = CNTW'(CHANNELS - 1);

  // fingerprint word order
  localparam logic [2:0] W_CNT = 3'd0, W_CLO = 3'd1, W_CHI = 3'd2, W_EN = 3'd3;
  localparam logic [2:0] W_DLO = 3'd0, W_DHI = 3'd1, W_TLO = 3'd2, W_THI = 3'd3;
  localparam logic [2:0] W_STK = 3'd4, W_DUP = 3'd5;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_OBS_CH   = 11'b00000000010,
    S_OBS_DEN  = 11'b00000000100,
    S_OBS_RATE = 11'b00000001000,
    S_HLT_DIV  = 11'b00000010000,
    S_POL_SCAN = 11'b00000100000,
    S_POL_MLO  = 11'b00001000000,
    S_POL_MHI  = 11'b00010000000,
    S_POL_FIN  = 11'b00100000000,
    S_FNV      = 11'b01000000000,
    S_RESP     = 11'b10000000000
  } state_e;

  state_e state_q;

  // configuration
  logic [3:0]  en_q;
  logic [31:0] lo_lim_q, hi_lim_q;
  logic        cfg_we, cfg_clear;

  // statistics
  logic [31:0] win_cnt_q, clk_lo_q, clk_hi_q;
  logic [31:0] dlo_q [CHANNELS];
  logic [31:0] dhi_q [CHANNELS];
  logic [31:0] tlo_q [CHANNELS];
  logic [31:0] thi_q [CHANNELS];
  logic [47:0] ttot_q [CHANNELS];
  logic [31:0] stuck_q [CHANNELS];
  logic [31:0] dup_q [CHANNELS];

  // sequencer data
  in_t         in_q;
  out_t        res_q, out_q;
  logic        out_valid_q;
  logic [CNTW-1:0] ch_q;
  logic [2:0]  k_q;
  logic [1:0]  byte_q;
  logic        glob_q;
  logic [31:0] h_q;
  logic [25:0] dens_q;
  logic [31:0] acc_dlo_q, acc_dhi_q, acc_tlo_q, acc_thi_q;
  logic [63:0] mulp_q;
  logic [29:0] lodiv_q;

  logic        in_acc, obs_go, chan_upd, nodata, chan_sel;
  logic [CW-1:0] ci, qi;
  logic [1:0]  lane;
  logic [15:0] ones_l, edges_l;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_clear   = cfg_we && (cfg_index_i == REG_ENABLE);

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign ci   = ch_q[CW-1:0];
  assign qi   = in_data_i.query_channel[CW-1:0];
  assign lane = 2'(ch_q);
  assign ones_l  = lane16(in_q.ones_ch01, in_q.ones_ch23, lane);
  assign edges_l = lane16(in_q.edges_ch01, in_q.edges_ch23, lane);
  assign chan_sel = in_q.window_channels[lane] && en_q[lane];

  assign obs_go = in_acc && (in_data_i.opcode == OP_OBSERVE)
               && (in_data_i.window_clocks != '0)
               && ((in_data_i.window_channels & en_q) != '0);
  assign nodata = ({28'd0, in_data_i.query_channel} >= 32'(CHANNELS))
               || (win_cnt_q == '0) || !en_q[in_data_i.query_channel[1:0]];
  assign chan_upd = (state_q == S_OBS_RATE) && div_rsp.done;

  // divider requests
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = {22'd0, {10'd0, ones_l} * {16'd0, PERMILLE}};
    div_req.den   = {16'd0, in_q.window_clocks};
    case (state_q)
      S_IDLE: begin
        div_req.start = in_acc && (in_data_i.opcode == OP_HEALTH) && !nodata;
        div_req.num   = ttot_q[qi];
        div_req.den   = win_cnt_q;
      end
      S_OBS_CH: begin
        div_req.start = (ch_q != CH_END) && chan_sel;
      end
      S_OBS_DEN: begin
        div_req.start = div_rsp.done;
        div_req.num   = {22'd0, {10'd0, edges_l} * {16'd0, PERMILLE}};
      end
      default: ;
    endcase
  end

  pchm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // health evaluation
  function automatic logic [9:0] sub_floor(logic [9:0] v, logic [9:0] d);
    return (v > d) ? v - d : 10'd0;
  endfunction

  logic [1:0]  h_lvl;
  logic [9:0]  h_score;
  logic [5:0]  h_rsn;
  logic [31:0] h_span;
  always_comb begin
    h_lvl   = LVL_GOOD;
    h_score = SCORE_FULL;
    h_rsn   = '0;
    h_span  = dhi_q[ci] - dlo_q[ci];
    if (stuck_q[ci] != '0) begin
      h_rsn = h_rsn | RSN_STUCK; h_score = sub_floor(h_score, PEN_STUCK); h_lvl = LVL_FAIL;
    end
    if (dup_q[ci] > (win_cnt_q >> 1)) begin
      h_rsn = h_rsn | RSN_DUP; h_score = sub_floor(h_score, PEN_DUP);
      if (h_lvl < LVL_WARN) h_lvl = LVL_WARN;
    end
    if (h_span > SPAN_LIMIT) begin
      h_rsn = h_rsn | RSN_SPAN; h_score = sub_floor(h_score, PEN_SPAN);
      if (h_lvl < LVL_WARN) h_lvl = LVL_WARN;
    end
    if (div_rsp.quot < AVG_LOW || div_rsp.quot > AVG_HIGH) begin
      h_rsn = h_rsn | RSN_EDGE; h_score = sub_floor(h_score, PEN_EDGE); h_lvl = LVL_FAIL;
    end
    if (clk_lo_q < lo_lim_q || clk_hi_q > hi_lim_q) begin
      h_rsn = h_rsn | RSN_CLOCK; h_score = sub_floor(h_score, PEN_CLOCK); h_lvl = LVL_FAIL;
    end
  end

  // policy evaluation
  function automatic logic [31:0] bound(logic [31:0] v, logic [31:0] lo, logic [31:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  logic [29:0] mul_a;
  logic [63:0] mul_p;
  logic [29:0] hidiv;
  logic [31:0] p_top, p_floor, p_lo1, p_ceil, p_grown_s, p_dce, p_tce;
  logic [32:0] p_grown, p_dsum, p_tsum;
  logic [31:0] p_dfl, p_tfl;
  always_comb begin
    mul_a = (state_q == S_POL_MLO) ? clk_lo_q[31:2] : clk_hi_q[31:2];
    mul_p = {34'd0, mul_a} * {32'd0, RECIP5};
    hidiv = mulp_q[63:34];
    p_top   = (hi_lim_q == '0) ? '0 : hi_lim_q - 32'd1;
    p_floor = bound(clk_lo_q - {2'd0, lodiv_q}, lo_lim_q, p_top);
    p_grown = {1'b0, clk_hi_q} + {3'd0, hidiv};
    p_grown_s = p_grown[32] ? '1 : p_grown[31:0];
    p_lo1   = (p_floor == '1) ? '1 : p_floor + 32'd1;
    p_ceil  = bound(p_grown_s, p_lo1, hi_lim_q);
    p_dfl   = bound((acc_dlo_q > 32'd60) ? acc_dlo_q - 32'd60 : 32'd10, 32'd10, 32'd450);
    p_dsum  = {1'b0, acc_dhi_q} + 33'd60;
    p_dce   = bound(p_dsum[32] ? '1 : p_dsum[31:0], 32'd550, 32'd990);
    p_tfl   = bound((acc_tlo_q > 32'd30) ? acc_tlo_q - 32'd30 : 32'd5, 32'd5, 32'd400);
    p_tsum  = {1'b0, acc_thi_q} + 33'd50;
    p_tce   = bound(p_tsum[32] ? '1 : p_tsum[31:0], 32'd500, 32'd990);
  end

  // fingerprint byte feed
  logic [31:0] f_word, f_next;
  logic [7:0]  f_byte;
  always_comb begin
    f_word = '0;
    if (glob_q) begin
      case (k_q)
        W_CNT:   f_word = win_cnt_q;
        W_CLO:   f_word = clk_lo_q;
        W_CHI:   f_word = clk_hi_q;
        W_EN:    f_word = {28'd0, en_q};
        default: f_word = '0;
      endcase
    end else begin
      case (k_q)
        W_DLO:   f_word = dlo_q[ci];
        W_DHI:   f_word = dhi_q[ci];
        W_TLO:   f_word = tlo_q[ci];
        W_THI:   f_word = thi_q[ci];
        W_STK:   f_word = stuck_q[ci];
        W_DUP:   f_word = dup_q[ci];
        default: f_word = '0;
      endcase
    end
    f_byte = f_word[{byte_q, 3'b000} +: 8];
    f_next = 32'((h_q ^ {24'd0, f_byte}) * FNV_PRIME);
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= '0;
      lo_lim_q <= CLK_LO_RESET;
      hi_lim_q <= CLK_HI_RESET;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_ENABLE: en_q     <= cfg_data_i[3:0];
        REG_CLK_LO: lo_lim_q <= cfg_data_i;
        REG_CLK_HI: hi_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cnt_q <= '0;
      clk_lo_q  <= '1;
      clk_hi_q  <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        dlo_q[c] <= '1; dhi_q[c] <= '0; tlo_q[c] <= '1; thi_q[c] <= '0;
        ttot_q[c] <= '0; stuck_q[c] <= '0; dup_q[c] <= '0;
      end
    end else if (cfg_clear) begin
      win_cnt_q <= '0;
      clk_lo_q  <= '1;
      clk_hi_q  <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        dlo_q[c] <= '1; dhi_q[c] <= '0; tlo_q[c] <= '1; thi_q[c] <= '0;
        ttot_q[c] <= '0; stuck_q[c] <= '0; dup_q[c] <= '0;
      end
    end else begin
      if (obs_go) begin
        win_cnt_q <= win_cnt_q + 32'd1;
        if (in_data_i.clock_rate_hz < clk_lo_q) clk_lo_q <= in_data_i.clock_rate_hz;
        if (in_data_i.clock_rate_hz > clk_hi_q) clk_hi_q <= in_data_i.clock_rate_hz;
      end
      if (chan_upd) begin
        ttot_q[ci] <= ttot_q[ci] + {16'd0, div_rsp.quot[31:0]};
        if ({6'd0, dens_q} < dlo_q[ci]) dlo_q[ci] <= {6'd0, dens_q};
        if ({6'd0, dens_q} > dhi_q[ci]) dhi_q[ci] <= {6'd0, dens_q};
        if (div_rsp.quot[31:0] < tlo_q[ci]) tlo_q[ci] <= div_rsp.quot[31:0];
        if (div_rsp.quot[31:0] > thi_q[ci]) thi_q[ci] <= div_rsp.quot[31:0];
        if (ones_l == '0 || ones_l == in_q.window_clocks) stuck_q[ci] <= stuck_q[ci] + 32'd1;
        if (lane != 2'd0 && in_q.duplicate_bits[lane]) dup_q[ci] <= dup_q[ci] + 32'd1;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      ch_q        <= '0;
      k_q         <= '0;
      byte_q      <= '0;
      glob_q      <= 1'b0;
    end else begin
      // the response step reloads the output register itself
      if (out_valid_q && !out_stall_i && state_q != S_RESP) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            in_q  <= in_data_i;
            res_q <= '0;
            case (in_data_i.opcode)
              OP_OBSERVE: begin
                ch_q    <= '0;
                state_q <= obs_go ? S_OBS_CH : S_RESP;
              end
              OP_HEALTH: begin
                ch_q <= CNTW'(qi);
                if (nodata) begin
                  res_q.reason_bits <= RSN_NODATA;
                  state_q <= S_RESP;
                end else begin
                  state_q <= S_HLT_DIV;
                end
              end
              OP_POLICY: begin
                ch_q      <= '0;
                acc_dlo_q <= 32'd1000;
                acc_dhi_q <= '0;
                acc_tlo_q <= 32'd1000;
                acc_thi_q <= '0;
                state_q   <= (win_cnt_q < MIN_WINDOWS) ? S_RESP : S_POL_SCAN;
              end
              default: begin
                h_q     <= FNV_OFFSET;
                ch_q    <= '0;
                k_q     <= '0;
                byte_q  <= '0;
                glob_q  <= 1'b1;
                state_q <= S_FNV;
              end
            endcase
          end
        end
        S_OBS_CH: begin
          if (ch_q == CH_END) begin
            res_q.ok <= 1'b1;
            state_q  <= S_RESP;
          end else if (chan_sel) begin
            state_q <= S_OBS_DEN;
          end else begin
            ch_q <= ch_q + 1'b1;
          end
        end
        S_OBS_DEN: begin
          if (div_rsp.done) begin
            dens_q  <= div_rsp.quot[25:0];
            state_q <= S_OBS_RATE;
          end
        end
        S_OBS_RATE: begin
          if (div_rsp.done) begin
            ch_q    <= ch_q + 1'b1;
            state_q <= S_OBS_CH;
          end
        end
        S_HLT_DIV: begin
          if (div_rsp.done) begin
            res_q.health_level <= h_lvl;
            res_q.health_score <= h_score;
            res_q.reason_bits  <= h_rsn;
            state_q <= S_RESP;
          end
        end
        S_POL_SCAN: begin
          if (ch_q == CH_END) begin
            state_q <= S_POL_MLO;
          end else begin
            if (en_q[lane]) begin
              if (dlo_q[ci] < acc_dlo_q) acc_dlo_q <= dlo_q[ci];
              if (dhi_q[ci] > acc_dhi_q) acc_dhi_q <= dhi_q[ci];
              if (tlo_q[ci] < acc_tlo_q) acc_tlo_q <= tlo_q[ci];
              if (thi_q[ci] > acc_thi_q) acc_thi_q <= thi_q[ci];
            end
            ch_q <= ch_q + 1'b1;
          end
        end
        S_POL_MLO: begin
          mulp_q  <= mul_p;
          state_q <= S_POL_MHI;
        end
        S_POL_MHI: begin
          lodiv_q <= mulp_q[63:34];
          mulp_q  <= mul_p;
          state_q <= S_POL_FIN;
        end
        S_POL_FIN: begin
          res_q.ok               <= 1'b1;
          res_q.density_floor    <= p_dfl[9:0];
          res_q.density_ceiling  <= p_dce[9:0];
          res_q.edge_floor       <= p_tfl[9:0];
          res_q.edge_ceiling     <= p_tce[9:0];
          res_q.clock_floor_hz   <= p_floor;
          res_q.clock_ceiling_hz <= p_ceil;
          res_q.policy_channels  <= en_q;
          state_q <= S_RESP;
        end
        S_FNV: begin
          h_q    <= f_next;
          byte_q <= byte_q + 1'b1;
          if (byte_q == 2'd3) begin
            if (glob_q) begin
              if (k_q == W_EN) begin
                glob_q <= 1'b0;
                k_q    <= '0;
                ch_q   <= '0;
              end else begin
                k_q <= k_q + 1'b1;
              end
            end else if (k_q == W_DUP) begin
              k_q <= '0;
              if (ch_q == CH_LAST) begin
                res_q.fingerprint <= f_next;
                state_q <= S_RESP;
              end else begin
                ch_q <= ch_q + 1'b1;
              end
            end else begin
              k_q <= k_q + 1'b1;
            end
          end
        end
        S_RESP: begin
          // move the result once the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_clear |=> (win_cnt_q == $past(win_cnt_q)
                    || win_cnt_q == $past(win_cnt_q) + 32'd1))
    else $error("window count jumped");

  a_clock_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_cnt_q != '0) |-> (clk_lo_q <= clk_hi_q))
    else $error("clock lowest above highest");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("output loaded outside response step");

endmodule

// ===== design/pchm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pchm_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pchm_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pchm_pkg::div_req_t req_i,
  output pchm_pkg::div_rsp_t rsp_o
);
  import pchm_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_NW);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_NW - 1);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIV_NW-1:0] num_q;
  logic [DIV_DW-1:0] den_q, rem_q;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem_q, num_q[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        rem_q <= fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
        num_q <= {num_q[DIV_NW-2:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        num_q  <= req_i.num;
        den_q  <= req_i.den;
        rem_q  <= '0;
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PDM channel health monitor: directed and random
// windows, queries, policies and fingerprints checked against a predictor.
// ----------------------------------------------------------------------------
import pchm_pkg::*;

class health_scoreboard;
  // register copies
  logic [3:0]  enable_bits;
  logic [31:0] clk_lo_limit;
  logic [31:0] clk_hi_limit;
  // statistics
  logic [31:0] windows;
  logic [31:0] clk_min, clk_max;
  logic [31:0] dens_min[4], dens_max[4], rate_min[4], rate_max[4];
  logic [47:0] rate_sum[4];
  logic [31:0] stuck_n[4], dup_n[4];
  out_t        pending[$];
  int          mismatches;

  function void clear_stats();
    windows = '0;
    clk_min = '1;
    clk_max = '0;
    for (int c = 0; c < 4; c++) begin
      dens_min[c] = '1; dens_max[c] = '0;
      rate_min[c] = '1; rate_max[c] = '0;
      rate_sum[c] = '0; stuck_n[c] = '0; dup_n[c] = '0;
    end
  endfunction

  function void reset_all();
    enable_bits = '0;
    clk_lo_limit = CLK_LO_RESET;
    clk_hi_limit = CLK_HI_RESET;
    clear_stats();
    mismatches = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    case (idx)
      REG_ENABLE: begin
        clear_stats();
        enable_bits = value[3:0];
      end
      REG_CLK_LO: clk_lo_limit = value;
      REG_CLK_HI: clk_hi_limit = value;
      default: ;
    endcase
  endfunction

  static function logic [31:0] clamp32(logic [31:0] v, logic [31:0] lo, logic [31:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  static function logic [31:0] fnv_mix(logic [31:0] h, logic [31:0] w);
    for (int i = 0; i < 4; i++) begin
      h = h ^ {24'd0, w[i*8 +: 8]};
      h = h * FNV_PRIME;
    end
    return h;
  endfunction

  static function logic [9:0] drop(logic [9:0] s, logic [9:0] d);
    return (s > d) ? s - d : 10'd0;
  endfunction

  function void note_word(in_t w);
    out_t r;
    logic [31:0] ones, edges, dens, tr, span, lo, hi, top, fl, lo1;
    logic [47:0] avg;
    logic [32:0] grown;
    logic [3:0]  qc;
    r = '0;
    case (w.opcode)
      OP_OBSERVE: begin
        if (w.window_clocks != 0 && (w.window_channels & enable_bits) != 0) begin
          windows++;
          if (w.clock_rate_hz < clk_min) clk_min = w.clock_rate_hz;
          if (w.clock_rate_hz > clk_max) clk_max = w.clock_rate_hz;
          for (int c = 0; c < 4; c++) begin
            if (w.window_channels[c] && enable_bits[c]) begin
              ones = 32'(lane16(w.ones_ch01, w.ones_ch23, 2'(c)));
              edges = 32'(lane16(w.edges_ch01, w.edges_ch23, 2'(c)));
              dens = (ones * 1000) / w.window_clocks;
              tr = (edges * 1000) / w.window_clocks;
              rate_sum[c] = rate_sum[c] + tr;
              if (dens < dens_min[c]) dens_min[c] = dens;
              if (dens > dens_max[c]) dens_max[c] = dens;
              if (tr < rate_min[c]) rate_min[c] = tr;
              if (tr > rate_max[c]) rate_max[c] = tr;
              if (ones == 0 || ones == w.window_clocks) stuck_n[c]++;
              if (c > 0 && w.duplicate_bits[c]) dup_n[c]++;
            end
          end
          r.ok = 1'b1;
        end
      end
      OP_HEALTH: begin
        qc = w.query_channel;
        if (qc >= 4 || windows == 0 || !enable_bits[qc[1:0]]) begin
          r.reason_bits = RSN_NODATA;
        end else begin
          r.health_level = LVL_GOOD;
          r.health_score = SCORE_FULL;
          span = dens_max[qc[1:0]] - dens_min[qc[1:0]];
          avg = rate_sum[qc[1:0]] / {16'd0, windows};
          if (stuck_n[qc[1:0]] != 0) begin
            r.reason_bits |= RSN_STUCK;
            r.health_score = drop(r.health_score, PEN_STUCK);
            r.health_level = LVL_FAIL;
          end
          if (dup_n[qc[1:0]] > windows / 2) begin
            r.reason_bits |= RSN_DUP;
            r.health_score = drop(r.health_score, PEN_DUP);
            if (r.health_level < LVL_WARN) r.health_level = LVL_WARN;
          end
          if (span > SPAN_LIMIT) begin
            r.reason_bits |= RSN_SPAN;
            r.health_score = drop(r.health_score, PEN_SPAN);
            if (r.health_level < LVL_WARN) r.health_level = LVL_WARN;
          end
          if (avg < AVG_LOW || avg > AVG_HIGH) begin
            r.reason_bits |= RSN_EDGE;
            r.health_score = drop(r.health_score, PEN_EDGE);
            r.health_level = LVL_FAIL;
          end
          if (clk_min < clk_lo_limit || clk_max > clk_hi_limit) begin
            r.reason_bits |= RSN_CLOCK;
            r.health_score = drop(r.health_score, PEN_CLOCK);
            r.health_level = LVL_FAIL;
          end
        end
      end
      OP_POLICY: begin
        if (windows >= MIN_WINDOWS) begin
          logic [31:0] dlo, dhi, tlo, thi;
          dlo = 1000; dhi = 0; tlo = 1000; thi = 0;
          for (int c = 0; c < 4; c++) begin
            if (enable_bits[c]) begin
              if (dens_min[c] < dlo) dlo = dens_min[c];
              if (dens_max[c] > dhi) dhi = dens_max[c];
              if (rate_min[c] < tlo) tlo = rate_min[c];
              if (rate_max[c] > thi) thi = rate_max[c];
            end
          end
          r.density_floor = 10'(clamp32(dlo > 60 ? dlo - 60 : 10, 10, 450));
          r.density_ceiling = 10'(clamp32(dhi > 32'hFFFF_FFC3 ? '1 : dhi + 60, 550, 990));
          r.edge_floor = 10'(clamp32(tlo > 30 ? tlo - 30 : 5, 5, 400));
          r.edge_ceiling = 10'(clamp32(thi > 32'hFFFF_FFCD ? '1 : thi + 50, 500, 990));
          top = (clk_hi_limit == 0) ? 32'd0 : clk_hi_limit - 1;
          fl = clamp32(clk_min - clk_min / 20, clk_lo_limit, top);
          grown = {1'b0, clk_max} + {1'b0, clk_max / 20};
          hi = grown[32] ? 32'hFFFF_FFFF : grown[31:0];
          lo1 = (fl == '1) ? fl : fl + 1;
          r.ok = 1'b1;
          r.clock_floor_hz = fl;
          r.clock_ceiling_hz = clamp32(hi, lo1, clk_hi_limit);
          r.policy_channels = enable_bits;
        end
      end
      default: begin
        lo = FNV_OFFSET;
        lo = fnv_mix(lo, windows);
        lo = fnv_mix(lo, clk_min);
        lo = fnv_mix(lo, clk_max);
        lo = fnv_mix(lo, {28'd0, enable_bits});
        for (int c = 0; c < 4; c++) begin
          lo = fnv_mix(lo, dens_min[c]);
          lo = fnv_mix(lo, dens_max[c]);
          lo = fnv_mix(lo, rate_min[c]);
          lo = fnv_mix(lo, rate_max[c]);
          lo = fnv_mix(lo, stuck_n[c]);
          lo = fnv_mix(lo, dup_n[c]);
        end
        r.fingerprint = lo;
      end
    endcase
    pending.push_back(r);
  endfunction

  function void check_result(out_t got);
    out_t exp;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word %h", got);
      return;
    end
    exp = pending.pop_front();
    if (got !== exp) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch ok %b/%b lvl %0d/%0d score %0d/%0d rsn %h/%h",
                 exp.ok, got.ok, exp.health_level, got.health_level,
                 exp.health_score, got.health_score, exp.reason_bits, got.reason_bits);
        $display("  dens %0d-%0d/%0d-%0d edge %0d-%0d/%0d-%0d",
                 exp.density_floor, exp.density_ceiling, got.density_floor,
                 got.density_ceiling, exp.edge_floor, exp.edge_ceiling,
                 got.edge_floor, got.edge_ceiling);
        $display("  clk %0d-%0d/%0d-%0d ch %h/%h fp %h/%h",
                 exp.clock_floor_hz, exp.clock_ceiling_hz, got.clock_floor_hz,
                 got.clock_ceiling_hz, exp.policy_channels, got.policy_channels,
                 exp.fingerprint, got.fingerprint);
      end
    end
  endfunction
endclass

module tb;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  health_scoreboard sb;
  bit   idle_on = 1'b1;
  bit   hold_off = 1'b0;
  int   cycles = 0;

  always #5 clk_i = ~clk_i;

  pdm_channel_health_monitor dut (.*);

  // receiver: random stall bursts and one long hold-off
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 7);
        out_stall_i <= 1'b1;
        repeat (n - 1) @(posedge clk_i);
        @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3_000_000) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic send_word(in_t w);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(w);
    // the block stalls its input while it works on a taken word
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, value);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // plausible window unless noisy: counts within the clock count
  function automatic in_t make_window(bit noisy);
    in_t w;
    logic [15:0] clocks;
    w = '0;
    w.opcode = OP_OBSERVE;
    clocks = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2000));
    if (clocks == 0 && !noisy) clocks = 1;
    w.window_clocks = clocks;
    w.window_channels = 4'($urandom);
    w.duplicate_bits = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd0;
    w.clock_rate_hz = ($urandom_range(0, 9) == 0) ? $urandom
                                                  : $urandom_range(900000, 5000000);
    for (int c = 0; c < 4; c++) begin
      logic [15:0] o, e;
      case ($urandom_range(0, 9))
        0: o = 0;
        1: o = clocks;
        default: o = (clocks == 0) ? 16'd0 : 16'($urandom_range(0, clocks));
      endcase
      e = (clocks == 0) ? 16'd0 : 16'($urandom_range(0, clocks));
      if (noisy) begin
        o = 16'($urandom);
        e = 16'($urandom);
      end
      if (c < 2) begin
        w.ones_ch01[c*16 +: 16] = o;
        w.edges_ch01[c*16 +: 16] = e;
      end else begin
        w.ones_ch23[(c-2)*16 +: 16] = o;
        w.edges_ch23[(c-2)*16 +: 16] = e;
      end
    end
    return w;
  endfunction

  function automatic in_t make_random_word();
    in_t w;
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return make_window(k < 5);
    w = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    w.opcode = (k < 80) ? OP_HEALTH : (k < 93) ? OP_POLICY : OP_FINGERPRINT;
    if (w.opcode == OP_HEALTH && $urandom_range(0, 3) != 0)
      w.query_channel = 4'($urandom_range(0, 3));
    return w;
  endfunction

  initial begin
    in_t w;
    sb = new();
    sb.reset_all();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: operations on empty statistics, then extremes
    w = '0;
    w.opcode = OP_FINGERPRINT; send_word(w);
    w.opcode = OP_POLICY; send_word(w);
    w.opcode = OP_HEALTH; send_word(w);
    w = make_window(0); send_word(w);      // rejected, nothing enabled
    drain();
    write_reg(REG_ENABLE, 32'hF);
    w = make_window(0); w.window_clocks = 0; send_word(w);
    w = '1; w.opcode = OP_OBSERVE; send_word(w);   // full-scale counts
    w = '0; w.window_clocks = 16'hFFFF; w.window_channels = 4'hF;
    w.duplicate_bits = 4'hF; send_word(w);         // stuck low everywhere
    w.clock_rate_hz = '1; w.ones_ch01 = 32'hFFFF_FFFF; w.ones_ch23 = '1; send_word(w);
    for (int i = 0; i < 8; i++) begin
      w = make_window(0); w.window_channels = 4'hF; send_word(w);
    end
    for (int q = 0; q < 6; q++) begin
      w = '0; w.opcode = OP_HEALTH; w.query_channel = (q == 5) ? 4'hF : 4'(q);
      send_word(w);
    end
    w = '0; w.opcode = OP_POLICY; send_word(w);
    w.opcode = OP_FINGERPRINT; send_word(w);
    drain();
    write_reg(REG_CLK_LO, 32'd0);
    write_reg(REG_CLK_HI, 32'd0);
    w = '0; w.opcode = OP_POLICY; send_word(w);
    drain();
    write_reg(REG_CLK_LO, 32'hFFFF_FFFF);
    write_reg(REG_CLK_HI, 32'hFFFF_FFFF);
    w = '0; w.opcode = OP_POLICY; send_word(w);
    w.opcode = OP_HEALTH; w.query_channel = 4'd1; send_word(w);
    drain();

    // random phases across register settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_ENABLE, (ph == 7) ? 32'hFFFF_FFF0 : $urandom);
      if (ph == 1) begin
        write_reg(REG_CLK_LO, CLK_LO_RESET);
        write_reg(REG_CLK_HI, CLK_HI_RESET);
      end else if (ph > 1) begin
        write_reg(REG_CLK_LO, $urandom_range(0, 2000000));
        write_reg(REG_CLK_HI, (ph == 5) ? 32'hFFFF_FFFF : $urandom_range(3000000, 6000000));
      end
      if (ph == 6) idle_on = 1'b0;
      if (ph == 3) hold_off = 1'b1;
      for (int i = 0; i < 200; i++) begin
        send_word(make_random_word());
        if (ph == 4 && i == 100) while (sb.pending.size() != 0) @(posedge clk_i);
      end
      drain();
    end

    if (sb.mismatches == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule

// ===== files.f =====
design/pchm_pkg.sv
design/pchm_div.sv
design/pdm_channel_health_monitor.sv
verif/tb.sv
